// ===== src/assert_macros.svh =====
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MT_ASSERT(lbl, clk, rst, prop, msg)
`define MT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/mt64_pkg.sv =====
`default_nettype none

package mt64_pkg;

  localparam int unsigned WORDS  = 312;
  localparam int unsigned IDX_W  = $clog2(WORDS);
  localparam int unsigned WORD_W = 64;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WORDS - 1);
  localparam logic [IDX_W-1:0] MID_IDX   = IDX_W'(156);
  localparam logic [IDX_W-1:0] POS_END   = IDX_W'(WORDS);
  localparam logic [IDX_W-1:0] POS_RESET = IDX_W'(WORDS + 1);

  localparam logic [WORD_W-1:0] MATRIX    = 64'hb502_6f5a_a966_19e9;
  localparam logic [WORD_W-1:0] INIT_MUL  = 64'd6364136223846793005;
  localparam int unsigned       SEED_SHIFT = 62;
  localparam logic [WORD_W-1:0] LOW_MASK  = 64'h0000_0000_7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_M1 = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_M2 = 64'h71d6_7fff_eda6_0000;
  localparam logic [WORD_W-1:0] TEMPER_M3 = 64'hfff7_eee0_0000_0000;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_M0,
    S_SEED_M1,
    S_SEED_M2,
    S_SEED_M3,
    S_SEED_WR,
    S_TW_PRIME,
    S_TW_ISSUE,
    S_TW_WRITE,
    S_DRAW_READ,
    S_DRAW_OUT
  } state_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ ((y >> 29) & TEMPER_M1);
    y = y ^ ((y << 17) & TEMPER_M2);
    y = y ^ ((y << 37) & TEMPER_M3);
    y = y ^ (y >> 43);
    return y;
  endfunction

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] mid);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    x = (cur & ~LOW_MASK) | (nxt & LOW_MASK);
    y = x >> 1;
    if (x[0]) begin
      y = y ^ MATRIX;
    end
    return mid ^ y;
  endfunction

endpackage

`default_nettype wire

// ===== src/mt64_ram.sv =====
`default_nettype none

module mt64_ram #(
  parameter int unsigned DEPTH  = mt64_pkg::WORDS,
  parameter int unsigned WIDTH  = mt64_pkg::WORD_W,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/mt64_mul.sv =====
`default_nettype none

module mt64_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

// ===== src/mersenne_twister_64_unit.sv =====
// channel   signals                     handshake
// request   cmd, seed_value             accepted when start is high and busy is low
// result    random_word                 valid for one cycle while done is high
//
// a seeded draw keeps busy high through S_DRAW_READ and S_DRAW_OUT; done follows in the next cycle
// a draw before the first seed leaves busy low and gives zero in the next cycle
// a draw at the end of the words first twists them: after S_TW_PRIME, each word takes
// an S_TW_ISSUE and an S_TW_WRITE state, as each write waits on its registered reads
// a seed keeps busy high through S_SEED_M0 to S_SEED_WR for each of words 1 to 311, three products and a write per word
// reset clears the sequencer, not the words; the receiver cannot stall
`default_nettype none

`include "assert_macros.svh"

module mersenne_twister_64_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd,
  input  wire logic [31:0] seed_value,
  output logic      [63:0] random_word,
  output logic             done
);

  import mt64_pkg::*;

  state_t state, state_next;

  logic [IDX_W-1:0]  pos, pos_next;
  logic [IDX_W-1:0]  k, k_next;
  logic              seeded, seeded_next;
  logic [WORD_W-1:0] cur, cur_next;
  logic [WORD_W-1:0] prev, prev_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] word_next;
  logic              done_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_prod;

  logic [IDX_W-1:0]  nxt_idx;
  logic [IDX_W-1:0]  mid_idx;
  logic [WORD_W-1:0] seed_mix;

  mt64_ram #(
    .DEPTH  (WORDS),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mt64_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  assign nxt_idx  = (k == LAST_IDX) ? '0 : k + IDX_W'(1);
  assign mid_idx  = (k < MID_IDX) ? k + MID_IDX : k - MID_IDX;
  assign seed_mix = prev ^ (prev >> SEED_SHIFT);
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pos    <= POS_RESET;
      seeded <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      pos    <= pos_next;
      seeded <= seeded_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k           <= k_next;
    cur         <= cur_next;
    prev        <= prev_next;
    acc         <= acc_next;
    random_word <= word_next;
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    k_next      = k;
    seeded_next = seeded;
    cur_next    = cur;
    prev_next   = prev;
    acc_next    = acc;
    word_next   = random_word;
    done_next   = 1'b0;
    we          = 1'b0;
    waddr       = k;
    wdata       = acc + WORD_W'(k);
    raddr_a     = k;
    raddr_b     = mid_idx;
    mul_a       = seed_mix[31:0];
    mul_b       = INIT_MUL[31:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_SEED) begin
            we          = 1'b1;
            waddr       = '0;
            wdata       = WORD_W'(seed_value);
            prev_next   = WORD_W'(seed_value);
            k_next      = IDX_W'(1);
            seeded_next = 1'b1;
            state_next  = S_SEED_M0;
          end else if (!seeded) begin
            // no seed yet, so every draw gives zero without reading the words
            word_next = '0;
            done_next = 1'b1;
          end else if (pos >= POS_END) begin
            state_next = S_TW_PRIME;
          end else begin
            state_next = S_DRAW_READ;
          end
        end
      end

      // low 64 bits of seed_mix * INIT_MUL in three partial products
      S_SEED_M0: begin
        mul_a      = seed_mix[31:0];
        mul_b      = INIT_MUL[31:0];
        state_next = S_SEED_M1;
      end

      S_SEED_M1: begin
        mul_a      = seed_mix[63:32];
        mul_b      = INIT_MUL[31:0];
        acc_next   = mul_prod;
        state_next = S_SEED_M2;
      end

      S_SEED_M2: begin
        mul_a      = seed_mix[31:0];
        mul_b      = INIT_MUL[63:32];
        acc_next   = acc + {mul_prod[31:0], 32'b0};
        state_next = S_SEED_M3;
      end

      S_SEED_M3: begin
        acc_next   = acc + {mul_prod[31:0], 32'b0};
        state_next = S_SEED_WR;
      end

      S_SEED_WR: begin
        we        = 1'b1;
        waddr     = k;
        wdata     = acc + WORD_W'(k);
        prev_next = acc + WORD_W'(k);
        if (k == LAST_IDX) begin
          pos_next   = POS_END;
          state_next = S_IDLE;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = S_SEED_M0;
        end
      end

      S_TW_PRIME: begin
        raddr_a    = '0;
        k_next     = '0;
        state_next = S_TW_ISSUE;
      end

      S_TW_ISSUE: begin
        cur_next   = rdata_a;
        raddr_a    = nxt_idx;
        raddr_b    = mid_idx;
        state_next = S_TW_WRITE;
      end

      S_TW_WRITE: begin
        // hold the next-word read so it becomes cur of the following word
        raddr_a = nxt_idx;
        we      = 1'b1;
        waddr   = k;
        wdata   = twist_word(cur, rdata_a, rdata_b);
        if (k == LAST_IDX) begin
          pos_next   = '0;
          state_next = S_DRAW_READ;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = S_TW_ISSUE;
        end
      end

      S_DRAW_READ: begin
        raddr_a    = pos;
        state_next = S_DRAW_OUT;
      end

      S_DRAW_OUT: begin
        word_next  = temper(rdata_a);
        done_next  = 1'b1;
        pos_next   = pos + IDX_W'(1);
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MT_ASSERT(a_seed_goes_busy, clk, rst, (start && !busy && cmd == CMD_SEED) |=> busy, "no fill")
  `MT_ASSERT(a_done_when_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `MT_ASSERT(a_draw_in_range, clk, rst, (state == S_DRAW_OUT) |-> (pos < POS_END), "draw past end")
  `MT_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> (!busy && !done), "active after reset")

endmodule

`default_nettype wire

// ===== tb/mersenne_twister_64_unit_tb.sv =====
module mersenne_twister_64_unit_tb;
  import mt64_pkg::*;

  localparam int unsigned ITEM_TOTAL  = 1300;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ROW_COUNT   = 20;

  typedef struct packed {
    logic        op;
    logic [31:0] seed;
    logic        typed;
    logic [63:0] word;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cmd = CMD_DRAW;
  logic [31:0] seed_value = '0;
  logic        busy;
  logic [63:0] random_word;
  logic        done;

  logic [63:0] twister_state [WORDS];
  int unsigned read_pos;
  logic [63:0] pending_words [$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;

  // draws before any seed give zero; the seed field is ignored on a draw
  stim_row_t directed_rows [ROW_COUNT] = '{
    '{CMD_DRAW, 32'h0000_0000, 1'b1, 64'h0},
    '{CMD_DRAW, 32'hffff_ffff, 1'b1, 64'h0},
    '{CMD_SEED, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'hffff_ffff, 1'b0, 64'h0},
    '{CMD_SEED, 32'hffff_ffff, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'hffff_ffff, 1'b0, 64'h0},
    '{CMD_SEED, 32'haaaa_aaaa, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h5555_5555, 1'b0, 64'h0},
    '{CMD_SEED, 32'h5555_5555, 1'b0, 64'h0},
    '{CMD_SEED, 32'h0000_1571, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_SEED, 32'h8000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_SEED, 32'h0000_0001, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 64'h0}
  };

  mersenne_twister_64_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .seed_value(seed_value),
    .random_word(random_word),
    .done(done)
  );

  always #10 clk = ~clk;

  function void clear_state();
    for (int unsigned k = 0; k < WORDS; k++) begin
      twister_state[k] = '0;
    end
    read_pos = WORDS + 1;
  endfunction

  function void twist_state();
    logic [63:0] mixed;
    logic [63:0] shifted;
    for (int unsigned k = 0; k < WORDS; k++) begin
      mixed = (twister_state[k] & ~LOW_MASK) | (twister_state[(k + 1) % WORDS] & LOW_MASK);
      shifted = mixed >> 1;
      if (mixed[0]) begin
        shifted = shifted ^ MATRIX;
      end
      twister_state[k] = twister_state[(k + WORDS / 2) % WORDS] ^ shifted;
    end
    read_pos = 0;
  endfunction

  function void seed_state(input logic [31:0] s);
    logic [63:0] prev;
    twister_state[0] = {32'h0, s};
    for (int unsigned k = 1; k < WORDS; k++) begin
      prev = twister_state[k - 1];
      twister_state[k] = INIT_MUL * (prev ^ (prev >> SEED_SHIFT)) + 64'(k);
    end
    read_pos = WORDS;
  endfunction

  function logic [63:0] draw_word();
    logic [63:0] y;
    if (read_pos >= WORDS) begin
      twist_state();
    end
    y = twister_state[read_pos];
    y = y ^ ((y >> 29) & TEMPER_M1);
    y = y ^ ((y << 17) & TEMPER_M2);
    y = y ^ ((y << 37) & TEMPER_M3);
    y = y ^ (y >> 43);
    read_pos++;
    return y;
  endfunction

  function int unsigned pick_gap();
    int unsigned g;
    int unsigned idle_pct;
    g = 0;
    case ((sent * 3) / ITEM_TOTAL)
      0:       idle_pct = 0;
      1:       idle_pct = 86;
      default: idle_pct = 10;
    endcase
    while ($urandom_range(99) < idle_pct && g < 40) begin
      g++;
    end
    return g;
  endfunction

  function logic [31:0] pick_seed();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic op, input logic [31:0] s, input int unsigned gap,
                              input logic typed, input logic [63:0] word);
    logic [63:0] w;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= op;
    seed_value <= s;
    do @(posedge clk); while (busy);
    if (op == CMD_SEED) begin
      seed_state(s);
    end else begin
      w = draw_word();
      pending_words.push_back(typed ? word : w);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        $error("random_word: expected none, actual %h", random_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (random_word !== want) begin
          $error("random_word: expected %h, actual %h", want, random_word);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned run_len;
    clear_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int unsigned r = 0; r < ROW_COUNT; r++) begin
      send_request(directed_rows[r].op, directed_rows[r].seed, r % 3,
                   directed_rows[r].typed, directed_rows[r].word);
    end

    // mostly seeded runs of draws, some long enough to wrap the words
    while (sent < ITEM_TOTAL) begin
      if ($urandom_range(99) < 70) begin
        send_request(CMD_SEED, pick_seed(), pick_gap(), 1'b0, 64'h0);
        sent++;
      end
      run_len = ($urandom_range(99) < 15) ? $urandom_range(650, 313) : $urandom_range(40, 1);
      if (run_len > ITEM_TOTAL - sent) begin
        run_len = ITEM_TOTAL - sent;
      end
      repeat (run_len) begin
        send_request(CMD_DRAW, $urandom(), pick_gap(), 1'b0, 64'h0);
        sent++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
